// ===== rtl/ultrasonic_range_average_detector_defines.svh =====
// assertion macros for the ultrasonic range averager checker
// no dependencies; included by files that hold concurrent assertions
`ifndef ULTRASONIC_RANGE_AVERAGE_DETECTOR_DEFINES_SVH
`define ULTRASONIC_RANGE_AVERAGE_DETECTOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define URAD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define URAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/urad_pkg.sv =====
// shared types, constants and the microcode table of the ultrasonic range averager
// no dependencies
`timescale 1ns / 1ps

package urad_pkg;

  localparam int CHAN_W      = 2;
  localparam int PULSE_W     = 16;
  localparam int AVG_W       = 15;
  localparam int FRAC_W      = 4;
  localparam int THR_W       = 8;
  localparam int SPIKE_W     = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int DIVC_W      = 4;
  localparam int US_PER_CM   = 58;

  localparam logic [THR_W-1:0]   THR_RESET_CM   = 8'd15;
  localparam logic [SPIKE_W-1:0] SPIKE_RESET_CM = 10'd200;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LIMIT        = 2'd1;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_UPD  = 3'd1;
  localparam step_t STEP_RD   = 3'd2;
  localparam step_t STEP_LOOP = 3'd3;
  localparam step_t STEP_DEN  = 3'd4;
  localparam step_t STEP_MUL  = 3'd5;
  localparam step_t STEP_DIV  = 3'd6;
  localparam step_t STEP_EMIT = 3'd7;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_RD_MORE,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  take;
    logic  upd;
    logic  rd;
    logic  acc;
    logic  den;
    logic  mul;
    logic  div;
    logic  emit;
    cond_t cond;
    step_t target;
  } uop_t;

  // one control word per step; jump to target when cond holds, else step + 1
  function automatic uop_t ucode_rom(input step_t step);
    uop_t u;
    u = '{take: 1'b0, upd: 1'b0, rd: 1'b0, acc: 1'b0, den: 1'b0, mul: 1'b0,
          div: 1'b0, emit: 1'b0, cond: COND_NEVER, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        u.take   = 1'b1;
        u.cond   = COND_NO_INPUT;
        u.target = STEP_IDLE;
      end
      STEP_UPD:  u.upd = 1'b1;
      STEP_RD:   u.rd  = 1'b1;
      STEP_LOOP: begin
        u.rd     = 1'b1;
        u.acc    = 1'b1;
        u.cond   = COND_RD_MORE;
        u.target = STEP_LOOP;
      end
      STEP_DEN:  u.den = 1'b1;
      STEP_MUL:  u.mul = 1'b1;
      STEP_DIV:  begin
        u.div    = 1'b1;
        u.cond   = COND_DIV_MORE;
        u.target = STEP_DIV;
      end
      // last step, falls through to step zero by counter wrap
      STEP_EMIT: begin
        u.emit   = 1'b1;
        u.cond   = COND_OUT_BUSY;
        u.target = STEP_EMIT;
      end
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/urad_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module urad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 30
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ultrasonic_range_average_detector.sv =====
// ultrasonic range averager top level: microcoded sequencer and datapath
// depends on urad_pkg and urad_ram
`timescale 1ns / 1ps

// Three-channel (NUM_CHANNELS) echo averager. Each input transfer carries a channel
// and an echo pulse width in us; a pulse shorter than 58 * spike_limit_cm us is
// written into that channel's WINDOW_LEN-entry ring, and every input gives one
// result: the window mean in cm with 4 fraction bits (truncated, saturated at
// 32767), a valid flag and an obstacle flag. One item is in work at a time, and
// the input stalls until its result is loaded: one ring entry is read per cycle
// through the single read port of the sample memory, and the divider retires one
// quotient bit per cycle. A finished result waits in the output register while
// the next item is taken. The ring needs no clearing pass after reset: entries
// past the fill count read as zero. Configuration writes are always accepted.
module ultrasonic_range_average_detector #(
  parameter int WINDOW_LEN   = 10,
  parameter int NUM_CHANNELS = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [urad_pkg::CHAN_W-1:0]     sensor_channel,
  input  logic [urad_pkg::PULSE_W-1:0]    echo_pulse_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [urad_pkg::CHAN_W-1:0]     result_channel,
  output logic [urad_pkg::AVG_W-1:0]      average_distance_x16,
  output logic                            average_valid,
  output logic                            obstacle_near,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [urad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urad_pkg::CFG_DATA_W-1:0] cfg_data
);

  import urad_pkg::*;

  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int DEPTH   = NUM_CHANNELS * WINDOW_LEN;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = PULSE_W + $clog2(WINDOW_LEN);
  localparam int NUM_W   = SUM_W + FRAC_W;
  localparam int DEN_W   = $clog2(US_PER_CM * WINDOW_LEN + 1);
  localparam int TPR_W   = DEN_W + THR_W;
  localparam int CMP_W   = (SUM_W > TPR_W) ? SUM_W : TPR_W;
  localparam int SAT_W   = (NUM_W > DEN_W + AVG_W) ? NUM_W : DEN_W + AVG_W;

  // sequencer
  step_t step, step_next;
  uop_t  uop;
  logic  cond_true;

  // configuration
  logic [THR_W-1:0]   thr;
  logic [PULSE_W-1:0] spike_us;

  // per-channel ring control
  logic [SLOT_W-1:0] write_slot     [NUM_CHANNELS];
  logic [CNT_W-1:0]  accepted_count [NUM_CHANNELS];

  // datapath registers
  logic [CHAN_W-1:0]  ch;
  logic [PULSE_W-1:0] pulse;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   rd_tag;
  logic [SUM_W-1:0]   sum;
  logic [DEN_W-1:0]   den;
  logic [TPR_W-1:0]   thr_prod;
  logic               sat;
  logic [DEN_W-1:0]   rem;
  logic [AVG_W-1:0]   num_lo;
  logic [AVG_W-1:0]   quo;
  logic [DIVC_W-1:0]  div_cnt;

  logic               in_xfer, out_busy, out_load;
  logic               ch_ok, keep;
  logic [CH_W-1:0]    ch_idx;
  logic [SLOT_W-1:0]  cur_slot;
  logic [CNT_W-1:0]   cur_cnt;
  logic               rd_go;
  logic [ADDR_W-1:0]  base, waddr, raddr;
  logic [PULSE_W-1:0] rdata;
  logic [NUM_W-1:0]   num;
  logic [DEN_W:0]     trial;
  logic               ge;

  assign uop       = ucode_rom(step);
  assign in_stall  = !uop.take;
  assign in_xfer   = in_valid && !in_stall;
  assign out_busy  = out_valid && out_stall;
  assign out_load  = uop.emit && !out_busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (uop.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_NO_INPUT: cond_true = !in_valid;
      COND_RD_MORE:  cond_true = rd_go;
      COND_DIV_MORE: cond_true = div_cnt != DIVC_W'(AVG_W - 1);
      COND_OUT_BUSY: cond_true = out_busy;
      default:       cond_true = 1'b0;
    endcase
    step_next = cond_true ? uop.target : step_t'(step + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= THR_RESET_CM;
      spike_us <= PULSE_W'(US_PER_CM * SPIKE_RESET_CM);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_OBSTACLE_THRESHOLD) begin
        thr <= cfg_data[THR_W-1:0];
      end else if (cfg_index == REG_SPIKE_LIMIT) begin
        spike_us <= PULSE_W'(US_PER_CM * cfg_data[SPIKE_W-1:0]);
      end
    end
  end

  // ring bookkeeping for the channel in work
  assign ch_ok    = {1'b0, ch} < (CHAN_W + 1)'(NUM_CHANNELS);
  assign ch_idx   = ch[CH_W-1:0];
  assign cur_slot = write_slot[ch_idx];
  assign cur_cnt  = accepted_count[ch_idx];
  assign keep     = ch_ok && (pulse < spike_us);
  assign base     = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_LEN);
  assign waddr    = base + ADDR_W'(cur_slot);
  assign raddr    = base + ADDR_W'(rd_idx[SLOT_W-1:0]);
  assign rd_go    = uop.rd && (rd_idx != CNT_W'(WINDOW_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        write_slot[i]     <= '0;
        accepted_count[i] <= '0;
      end
    end else if (uop.upd && keep) begin
      write_slot[ch_idx] <= (cur_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0
                          : SLOT_W'(cur_slot + 1'b1);
      if (cur_cnt != CNT_W'(WINDOW_LEN)) begin
        accepted_count[ch_idx] <= CNT_W'(cur_cnt + 1'b1);
      end
    end
  end

  urad_ram #(
    .WIDTH (PULSE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (uop.upd && keep),
    .waddr (waddr),
    .wdata (pulse),
    .re    (rd_go),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign num   = {sum, {FRAC_W{1'b0}}};
  assign trial = {rem, num_lo[AVG_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch    <= sensor_channel;
      pulse <= echo_pulse_us;
    end
    if (uop.upd) begin
      // out-of-range channel averages over nothing
      if (!ch_ok) begin
        cnt <= '0;
      end else if (keep && cur_cnt != CNT_W'(WINDOW_LEN)) begin
        cnt <= CNT_W'(cur_cnt + 1'b1);
      end else begin
        cnt <= cur_cnt;
      end
      sum    <= '0;
      rd_idx <= '0;
    end
    if (rd_go) begin
      rd_tag <= rd_idx;
      rd_idx <= CNT_W'(rd_idx + 1'b1);
    end
    // entries at or past the fill count were never written since reset
    if (uop.acc && rd_tag < cnt) begin
      sum <= SUM_W'(sum + SUM_W'(rdata));
    end
    if (uop.den) begin
      den <= DEN_W'(US_PER_CM * cnt);
    end
    if (uop.mul) begin
      thr_prod <= TPR_W'(den) * TPR_W'(thr);
      sat      <= SAT_W'(num) >= SAT_W'({den, {AVG_W{1'b0}}});
      rem      <= DEN_W'(num >> AVG_W);
      num_lo   <= num[AVG_W-1:0];
      div_cnt  <= '0;
    end
    // restoring division, one quotient bit per step
    if (uop.div) begin
      rem     <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo     <= {quo[AVG_W-2:0], ge};
      num_lo  <= {num_lo[AVG_W-2:0], 1'b0};
      div_cnt <= DIVC_W'(div_cnt + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_channel <= ch;
      average_valid  <= cnt != '0;
      obstacle_near  <= (cnt != '0) && (CMP_W'(sum) < CMP_W'(thr_prod));
      if (cnt == '0) begin
        average_distance_x16 <= '0;
      end else if (sat) begin
        average_distance_x16 <= '1;
      end else begin
        average_distance_x16 <= quo;
      end
    end
  end

endmodule

// ===== rtl/urad_checker.sv =====
// port-level checker for the ultrasonic range averager, bound to the top level
// depends on urad_pkg and ultrasonic_range_average_detector_defines.svh
`timescale 1ns / 1ps
`include "ultrasonic_range_average_detector_defines.svh"

module urad_checker #(
  parameter int NUM_CHANNELS = 3
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [urad_pkg::CHAN_W-1:0] result_channel,
  input logic [urad_pkg::AVG_W-1:0]  average_distance_x16,
  input logic                        average_valid,
  input logic                        obstacle_near
);

  import urad_pkg::*;

  logic                    chan_bad;
  logic                    empty_out;
  logic                    empty_ok;
  logic                    in_xfer;
  logic [CHAN_W+AVG_W+1:0] out_word;
  logic [CHAN_W+AVG_W+1:0] out_prev;
  logic                    held;

  assign chan_bad  = out_valid && ({1'b0, result_channel} >= (CHAN_W + 1)'(NUM_CHANNELS));
  assign empty_out = out_valid && !average_valid;
  assign empty_ok  = (average_distance_x16 == '0) && !obstacle_near;
  assign in_xfer   = in_valid && !in_stall;
  assign out_word  = {result_channel, average_distance_x16, average_valid, obstacle_near};
  assign held      = out_valid && (out_word == out_prev);

  // result word as it stood in the previous cycle
  always_ff @(posedge clk) begin
    out_prev <= out_word;
  end

  // an empty window reports no distance and no obstacle
  `URAD_ASSERT_SAME(a_empty_result, clk, rst, empty_out, empty_ok, "empty window result not zero")
  // unknown channel never reports a valid average
  `URAD_ASSERT_SAME(a_bad_channel, clk, rst, chan_bad, !average_valid, "valid avg on bad channel")
  // one item in work at a time
  `URAD_ASSERT_NEXT(a_one_item, clk, rst, in_xfer, in_stall, "input taken while item in work")
  `URAD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, held, "stalled result changed")

endmodule

bind ultrasonic_range_average_detector urad_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_urad_checker (.*);
